// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
`define ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, cond, prop)
`define ASSERT_NXT(lbl, cond, prop)
`endif

`endif

// ----- design/cal_pkg.sv -----
// ----------------------------------------------------------------------------
// cal_pkg
// shared types, constants and angle table for the complex accumulator alu
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cal_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_IW    = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int XW           = 35;
  localparam int ZW           = 25;
  localparam logic signed [ZW-1:0] ANGLE_LIMIT = 25'sd5898240;

  localparam logic [2:0] MODE_LOAD = 3'd0;
  localparam logic [2:0] MODE_ADD  = 3'd1;
  localparam logic [2:0] MODE_SUB  = 3'd2;
  localparam logic [2:0] MODE_MUL  = 3'd3;
  localparam logic [2:0] MODE_DIV  = 3'd4;

  typedef struct packed {
    logic        [2:0]  mode;
    logic signed [31:0] operand_re;
    logic signed [31:0] operand_im;
  } cal_cmd_t;

  typedef struct packed {
    logic signed [31:0] result_re;
    logic signed [31:0] result_im;
    logic        [31:0] magnitude;
    logic signed [23:0] angle_degrees;
    logic               divide_by_zero;
    logic               saturated;
  } cal_res_t;

  // atan(2^-i) in degrees, q8.16
  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:  v = 25'sd2949120;
      5'd1:  v = 25'sd1740967;
      5'd2:  v = 25'sd919879;
      5'd3:  v = 25'sd466945;
      5'd4:  v = 25'sd234379;
      5'd5:  v = 25'sd117304;
      5'd6:  v = 25'sd58666;
      5'd7:  v = 25'sd29335;
      5'd8:  v = 25'sd14668;
      5'd9:  v = 25'sd7334;
      5'd10: v = 25'sd3667;
      5'd11: v = 25'sd1833;
      5'd12: v = 25'sd917;
      5'd13: v = 25'sd458;
      5'd14: v = 25'sd229;
      5'd15: v = 25'sd115;
      5'd16: v = 25'sd57;
      5'd17: v = 25'sd29;
      5'd18: v = 25'sd14;
      5'd19: v = 25'sd7;
      5'd20: v = 25'sd4;
      5'd21: v = 25'sd2;
      5'd22: v = 25'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- design/cal_mult.sv -----
// ----------------------------------------------------------------------------
// cal_mult
// shared signed 32x32 multiplier with registered product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cal_mult (
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [63:0]      p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

`default_nettype wire

// ----- design/cal_div.sv -----
// ----------------------------------------------------------------------------
// cal_div
// restoring divider, one quotient bit per cycle, flags quotients past 33 bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cal_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] mag,
  input  wire logic [63:0] den,
  output logic             busy,
  output logic [32:0]      q,
  output logic             big
);

  localparam int QB = 33;
  localparam int SH = QB - cal_pkg::FRAC_BITS;

  logic [63:0] rem;
  logic [63:0] den_r;
  logic [QB-1:0] nlow;
  logic [5:0] cnt;
  logic [63:0] top;
  logic [63+cal_pkg::FRAC_BITS:0] num_full;
  logic [64:0] trial;
  logic        fits;

  assign top      = mag >> SH;
  assign num_full = {mag, {cal_pkg::FRAC_BITS{1'b0}}};
  assign trial    = {rem, nlow[QB-1]};
  assign fits     = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      den_r <= den;
      q     <= '0;
      if (top >= den) begin
        big  <= 1'b1;
        busy <= 1'b0;
      end else begin
        big  <= 1'b0;
        rem  <= top;
        nlow <= num_full[QB-1:0];
        cnt  <= 6'(QB);
        busy <= 1'b1;
      end
    end else if (busy) begin
      rem  <= fits ? 64'(trial - {1'b0, den_r}) : trial[63:0];
      q    <= {q[QB-2:0], fits};
      nlow <= {nlow[QB-2:0], 1'b0};
      cnt  <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/cal_sqrt.sv -----
// ----------------------------------------------------------------------------
// cal_sqrt
// bit-pair integer square root of a 64-bit value, one result bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cal_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] v,
  output logic             busy,
  output logic [31:0]      root
);

  logic [63:0] vs;
  logic [35:0] rem;
  logic [5:0]  cnt;
  logic [35:0] r2;
  logic [35:0] trial;

  assign r2    = {rem[33:0], vs[63:62]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      vs   <= v;
      rem  <= '0;
      root <= '0;
      cnt  <= 6'd32;
      busy <= 1'b1;
    end else if (busy) begin
      if (r2 >= trial) begin
        rem  <= r2 - trial;
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= r2;
        root <= {root[30:0], 1'b0};
      end
      vs  <= {vs[61:0], 2'b00};
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/cal_cordic.sv -----
// ----------------------------------------------------------------------------
// cal_cordic
// vectoring cordic, one micro-rotation per cycle, angle in degrees q8.16
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cal_cordic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] re,
  input  wire logic signed [31:0] im,
  output logic                    busy,
  output logic signed [23:0]      angle
);

  localparam int XW = cal_pkg::XW;
  localparam int ZW = cal_pkg::ZW;

  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  logic signed [ZW-1:0] z;
  logic [cal_pkg::CORDIC_IW-1:0] i;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] at;
  logic signed [XW-1:0] re_x;
  logic signed [XW-1:0] im_x;

  assign re_x = XW'(re);
  assign im_x = XW'(im);
  assign xs   = x >>> i;
  assign ys   = y >>> i;
  assign at   = cal_pkg::atan_deg(5'(i));

  always_comb begin
    priority if (z > cal_pkg::ANGLE_LIMIT) begin
      angle = 24'(cal_pkg::ANGLE_LIMIT);
    end else if (z < -cal_pkg::ANGLE_LIMIT) begin
      angle = 24'(-cal_pkg::ANGLE_LIMIT);
    end else begin
      angle = 24'(z);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      i    <= '0;
    end else if (start) begin
      i <= '0;
      priority if (im == 32'sd0) begin
        z    <= '0;
        busy <= 1'b0;
      end else if (re == 32'sd0) begin
        z    <= (im > 32'sd0) ? cal_pkg::ANGLE_LIMIT : -cal_pkg::ANGLE_LIMIT;
        busy <= 1'b0;
      end else begin
        x    <= (re < 32'sd0) ? -re_x : re_x;
        y    <= (re < 32'sd0) ? -im_x : im_x;
        z    <= '0;
        busy <= 1'b1;
      end
    end else if (busy) begin
      if (y >= 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end
      if (i == cal_pkg::CORDIC_IW'(cal_pkg::CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
      end else begin
        i <= i + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/complex_accumulator_alu.sv -----
// ----------------------------------------------------------------------------
// complex_accumulator_alu
// complex q16.16 accumulator with load, add, subtract, multiply and divide
// ----------------------------------------------------------------------------
// One request at a time. Every request squares the new result parts in
// two passes through the one shared 32x32 multiplier, then runs the
// 32-step square root for the magnitude alongside the 16-step cordic for
// the angle; multiply and divide add six more multiplier passes before
// that, and a divide by a nonzero operand adds two 33-step restoring
// divisions.
// A finished result sits in an output register until taken.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module complex_accumulator_alu (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire cal_pkg::cal_cmd_t cmd,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output cal_pkg::cal_res_t      res
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PROD = 4'd1;
  localparam logic [3:0] S_SEL  = 4'd2;
  localparam logic [3:0] S_DIV0 = 4'd3;
  localparam logic [3:0] S_DIV1 = 4'd4;
  localparam logic [3:0] S_POST = 4'd5;
  localparam logic [3:0] S_WAIT = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;
  localparam logic [3:0] S_SQ   = 4'd8;

  localparam int F = cal_pkg::FRAC_BITS;

  logic [3:0] state;
  logic [2:0] mode;
  logic signed [31:0] br, bi;
  logic signed [31:0] acc_re, acc_im;
  logic signed [31:0] nr, ni;
  logic dz, sat;
  logic [2:0] cnt;
  logic signed [65:0] sum0, sum1, sum2;

  logic signed [31:0] ma, mb;
  logic signed [63:0] p;
  logic signed [65:0] pe;

  logic        div_start;
  logic [63:0] div_mag;
  logic        div_busy, div_big;
  logic [32:0] div_q;
  logic        div_neg;
  logic        neg0, neg1;
  logic [65:0] abs0, abs1;

  logic        post_start;
  logic [63:0] sq_in;
  logic        sq_busy, co_busy;
  logic [31:0] root;
  logic signed [23:0] angle;

  logic signed [65:0] add_re, add_im, sub_re, sub_im;
  logic signed [65:0] mul_re, mul_im;
  logic [32:0] c_add_re, c_add_im, c_sub_re, c_sub_im, c_mul_re, c_mul_im;
  logic [32:0] c_div;

  function automatic logic [32:0] clip(input logic signed [65:0] v);
    logic [32:0] r;
    priority if (v > 66'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -66'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  cal_mult u_mult (
    .clk (clk),
    .a   (ma),
    .b   (mb),
    .p   (p)
  );

  cal_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (div_mag),
    .den   (sum2[63:0]),
    .busy  (div_busy),
    .q     (div_q),
    .big   (div_big)
  );

  cal_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (post_start),
    .v     (sq_in),
    .busy  (sq_busy),
    .root  (root)
  );

  cal_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (post_start),
    .re    (nr),
    .im    (ni),
    .busy  (co_busy),
    .angle (angle)
  );

  // multiplier operand schedule
  always_comb begin
    if (state == S_SQ) begin
      ma = (cnt == 3'd0) ? nr : ni;
      mb = (cnt == 3'd0) ? nr : ni;
    end else begin
      unique case (cnt)
        3'd0:    begin ma = acc_re; mb = br; end
        3'd1:    begin ma = acc_im; mb = bi; end
        3'd2:    begin ma = acc_re; mb = bi; end
        3'd3:    begin ma = acc_im; mb = br; end
        3'd4:    begin ma = br;     mb = br; end
        default: begin ma = bi;     mb = bi; end
      endcase
    end
  end

  assign pe       = 66'(p);
  assign cmd_ready = (state == S_IDLE);

  assign add_re = 66'(acc_re) + 66'(cmd.operand_re);
  assign add_im = 66'(acc_im) + 66'(cmd.operand_im);
  assign sub_re = 66'(acc_re) - 66'(cmd.operand_re);
  assign sub_im = 66'(acc_im) - 66'(cmd.operand_im);
  assign mul_re = sum0 >>> F;
  assign mul_im = sum1 >>> F;
  assign c_add_re = clip(add_re);
  assign c_add_im = clip(add_im);
  assign c_sub_re = clip(sub_re);
  assign c_sub_im = clip(sub_im);
  assign c_mul_re = clip(mul_re);
  assign c_mul_im = clip(mul_im);

  assign neg0 = sum0[65];
  assign neg1 = sum1[65];
  assign abs0 = neg0 ? 66'(-sum0) : 66'(sum0);
  assign abs1 = neg1 ? 66'(-sum1) : 66'(sum1);

  // sign and clip of a divider quotient
  always_comb begin
    if (div_neg) begin
      if (div_big || div_q > 33'h0_8000_0000) begin
        c_div = {1'b1, 32'h8000_0000};
      end else begin
        c_div = {1'b0, 32'(-$signed({1'b0, div_q}))};
      end
    end else begin
      if (div_big || div_q > 33'h0_7FFF_FFFF) begin
        c_div = {1'b1, 32'h7FFF_FFFF};
      end else begin
        c_div = {1'b0, div_q[31:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      acc_re     <= '0;
      acc_im     <= '0;
      div_start  <= 1'b0;
      post_start <= 1'b0;
      cnt        <= '0;
    end else begin
      div_start  <= 1'b0;
      post_start <= 1'b0;
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            mode <= cmd.mode;
            br   <= cmd.operand_re;
            bi   <= cmd.operand_im;
            dz   <= 1'b0;
            sat  <= 1'b0;
            nr   <= acc_re;
            ni   <= acc_im;
            cnt  <= '0;
            sum0 <= '0;
            sum1 <= '0;
            sum2 <= '0;
            state <= S_POST;
            unique case (cmd.mode)
              cal_pkg::MODE_LOAD: begin
                nr <= cmd.operand_re;
                ni <= cmd.operand_im;
              end
              cal_pkg::MODE_ADD: begin
                nr  <= c_add_re[31:0];
                ni  <= c_add_im[31:0];
                sat <= c_add_re[32] | c_add_im[32];
              end
              cal_pkg::MODE_SUB: begin
                nr  <= c_sub_re[31:0];
                ni  <= c_sub_im[31:0];
                sat <= c_sub_re[32] | c_sub_im[32];
              end
              cal_pkg::MODE_MUL, cal_pkg::MODE_DIV: begin
                state <= S_PROD;
              end
              default: begin
              end
            endcase
          end
        end
        S_PROD: begin
          unique case (cnt)
            3'd0: begin
            end
            3'd1: sum0 <= sum0 + pe;
            3'd2: sum0 <= (mode == cal_pkg::MODE_MUL) ? sum0 - pe : sum0 + pe;
            3'd3: sum1 <= (mode == cal_pkg::MODE_MUL) ? sum1 + pe : sum1 - pe;
            3'd4: sum1 <= sum1 + pe;
            default: sum2 <= sum2 + pe;
          endcase
          if (cnt == 3'd6) begin
            state <= S_SEL;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_SEL: begin
          if (mode == cal_pkg::MODE_MUL) begin
            nr    <= c_mul_re[31:0];
            ni    <= c_mul_im[31:0];
            sat   <= c_mul_re[32] | c_mul_im[32];
            state <= S_POST;
          end else if (br == 32'sd0 && bi == 32'sd0) begin
            dz    <= 1'b1;
            state <= S_POST;
          end else begin
            div_mag   <= abs0[63:0];
            div_neg   <= neg0;
            div_start <= 1'b1;
            state     <= S_DIV0;
          end
        end
        S_DIV0: begin
          if (!div_start && !div_busy) begin
            nr        <= c_div[31:0];
            sat       <= c_div[32];
            div_mag   <= abs1[63:0];
            div_neg   <= neg1;
            div_start <= 1'b1;
            state     <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (!div_start && !div_busy) begin
            ni    <= c_div[31:0];
            sat   <= sat | c_div[32];
            state <= S_POST;
          end
        end
        S_POST: begin
          acc_re <= nr;
          acc_im <= ni;
          cnt    <= '0;
          state  <= S_SQ;
        end
        S_SQ: begin
          unique case (cnt)
            3'd0: cnt <= 3'd1;
            3'd1: begin
              sq_in <= $unsigned(p);
              cnt   <= 3'd2;
            end
            default: begin
              sq_in      <= sq_in + $unsigned(p);
              post_start <= 1'b1;
              state      <= S_WAIT;
            end
          endcase
        end
        S_WAIT: begin
          if (!post_start && !sq_busy && !co_busy) begin
            state <= S_OUT;
          end
        end
        default: begin
          if (!res_valid || res_ready) begin
            res.result_re      <= nr;
            res.result_im      <= ni;
            res.magnitude      <= root;
            res.angle_degrees  <= angle;
            res.divide_by_zero <= dz;
            res.saturated      <= sat;
            res_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end
      endcase
    end
  end

  `ASSERT_NXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready)
  `ASSERT_IMP(a_flags_exclusive, res_valid, !(res.divide_by_zero && res.saturated))
  `ASSERT_IMP(a_angle_range, res_valid, (res.angle_degrees <= 24'sd5898240) && (res.angle_degrees >= -24'sd5898240))
  `ASSERT_IMP(a_units_idle, state == S_IDLE, !div_busy && !sq_busy && !co_busy)

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the complex accumulator alu: directed table, then
// random requests checked against a bit-exact accumulator predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import cal_pkg::*;

  localparam logic [2:0] MODE_SPARE_5 = 3'd5;
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic signed [31:0] Q_ONE = 32'sh00010000;
  localparam int RANDOM_ITEMS = 1930;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int HOLD_CYCLES  = 600;
  localparam int ATAN_DEG [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  typedef struct {
    cal_cmd_t c;
    bit       typed;
    cal_res_t r;
  } row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_ready;
  cal_cmd_t cmd = '0;
  logic     res_valid;
  logic     res_ready = 1'b0;
  cal_res_t res;

  logic signed [31:0] acc_re = '0;
  logic signed [31:0] acc_im = '0;
  cal_res_t pending_q[$];
  row_t     rows[$];
  int       errors = 0;
  int       cycles = 0;
  bit       quiet = 1'b0;
  bit       hold_req = 1'b0;
  bit       hold_done = 1'b0;
  int       hold_left = 0;
  int       run_left = 0;

  complex_accumulator_alu dut (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  always #5 clk = ~clk;

  // {clipped, value}
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return {1'b1, Q_MAX};
    if (v < -66'sd2147483648) return {1'b1, Q_MIN};
    return {1'b0, v[31:0]};
  endfunction

  // trunc((n << 16) / den) clipped
  function automatic logic [32:0] div_part(input logic signed [65:0] n,
                                           input logic [65:0] den);
    logic [99:0] num;
    logic [99:0] q;
    num = (n < 0) ? 100'(-n) : 100'(n);
    num = num << FRAC_BITS;
    q = num / 100'(den);
    if (n < 0) begin
      if (q > 100'h80000000) return {1'b1, Q_MIN};
      return {1'b0, 32'(-q)};
    end
    if (q > 100'h7fffffff) return {1'b1, Q_MAX};
    return {1'b0, q[31:0]};
  endfunction

  function automatic logic [31:0] root64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic logic signed [23:0] angle_deg(input logic signed [31:0] re,
                                                   input logic signed [31:0] im);
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] nx;
    logic signed [63:0] z;
    if (im == 0) return '0;
    if (re == 0) return (im > 0) ? 24'sd5898240 : -24'sd5898240;
    x = (re < 0) ? -64'(re) : 64'(re);
    y = (re < 0) ? -64'(im) : 64'(im);
    z = '0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ATAN_DEG[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ATAN_DEG[i];
      end
      x = nx;
    end
    if (z > 64'sd5898240) z = 64'sd5898240;
    if (z < -64'sd5898240) z = -64'sd5898240;
    return z[23:0];
  endfunction

  function automatic cal_res_t accumulate(input cal_cmd_t c);
    logic signed [65:0] ar, ai, br, bi;
    logic [65:0]        den;
    logic [32:0]        pr, pi;
    logic [63:0]        sq;
    cal_res_t           o;
    ar = 66'(acc_re);
    ai = 66'(acc_im);
    br = 66'(c.operand_re);
    bi = 66'(c.operand_im);
    pr = {1'b0, acc_re};
    pi = {1'b0, acc_im};
    o = '0;
    case (c.mode)
      MODE_LOAD: begin
        pr = {1'b0, c.operand_re};
        pi = {1'b0, c.operand_im};
      end
      MODE_ADD: begin
        pr = sat32(ar + br);
        pi = sat32(ai + bi);
      end
      MODE_SUB: begin
        pr = sat32(ar - br);
        pi = sat32(ai - bi);
      end
      MODE_MUL: begin
        pr = sat32((ar * br - ai * bi) >>> FRAC_BITS);
        pi = sat32((ar * bi + ai * br) >>> FRAC_BITS);
      end
      MODE_DIV: begin
        if (br == 0 && bi == 0) begin
          o.divide_by_zero = 1'b1;
        end else begin
          den = br * br + bi * bi;
          pr = div_part(ar * br + ai * bi, den);
          pi = div_part(ai * br - ar * bi, den);
        end
      end
      default: ;
    endcase
    acc_re = pr[31:0];
    acc_im = pi[31:0];
    o.saturated = pr[32] | pi[32];
    o.result_re = acc_re;
    o.result_im = acc_im;
    sq = 64'(64'(acc_re) * 64'(acc_re)) + 64'(64'(acc_im) * 64'(acc_im));
    o.magnitude = root64(sq);
    o.angle_degrees = angle_deg(acc_re, acc_im);
    return o;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 32'($urandom_range(0, 1) ? Q_MAX : Q_MIN);
      1: return '0;
      2, 3: return $urandom();
      default: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
    endcase
  endfunction

  task automatic add_row(input logic [2:0] m, input logic [31:0] re, input logic [31:0] im,
                         input bit typed, input cal_res_t r);
    row_t w;
    w.c = '{mode: m, operand_re: re, operand_im: im};
    w.typed = typed;
    w.r = r;
    rows.push_back(w);
  endtask

  task automatic send_request(input cal_cmd_t c, input bit typed, input cal_res_t r);
    cal_res_t p;
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (!cmd_ready);
    p = accumulate(c);
    pending_q.push_back(typed ? r : p);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: compare, then pick ready for the next cycle
  always @(posedge clk) begin
    cal_res_t e;
    if (!rst && res_valid && res_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, res);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (res.result_re !== e.result_re) begin
          $display("%0t result_re exp %h got %h", $time, e.result_re, res.result_re);
          errors++;
        end
        if (res.result_im !== e.result_im) begin
          $display("%0t result_im exp %h got %h", $time, e.result_im, res.result_im);
          errors++;
        end
        if (res.magnitude !== e.magnitude) begin
          $display("%0t magnitude exp %h got %h", $time, e.magnitude, res.magnitude);
          errors++;
        end
        if (res.angle_degrees !== e.angle_degrees) begin
          $display("%0t angle exp %h got %h", $time, e.angle_degrees, res.angle_degrees);
          errors++;
        end
        if (res.divide_by_zero !== e.divide_by_zero) begin
          $display("%0t divide_by_zero exp %b got %b", $time, e.divide_by_zero,
                   res.divide_by_zero);
          errors++;
        end
        if (res.saturated !== e.saturated) begin
          $display("%0t saturated exp %b got %b", $time, e.saturated, res.saturated);
          errors++;
        end
      end
    end
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else if (quiet) begin
      res_ready <= 1'b1;
    end else if (run_left == 0) begin
      run_left = $urandom_range(1, 16);
      res_ready <= ($urandom_range(0, 2) != 0);
    end else begin
      run_left--;
    end
  end

  initial begin
    cal_cmd_t c;
    add_row(MODE_LOAD, 0, 0, 1, '{0, 0, 0, 0, 0, 0});
    add_row(MODE_LOAD, Q_ONE, 0, 1, '{Q_ONE, 0, 32'h10000, 0, 0, 0});
    add_row(MODE_DIV, 0, 0, 1, '{Q_ONE, 0, 32'h10000, 0, 1, 0});
    add_row(MODE_LOAD, 0, Q_ONE, 1, '{0, Q_ONE, 32'h10000, 24'sd5898240, 0, 0});
    add_row(MODE_LOAD, 0, -Q_ONE, 1, '{0, -Q_ONE, 32'h10000, -24'sd5898240, 0, 0});
    add_row(MODE_LOAD, Q_MAX, Q_MAX, 0, '0);
    add_row(MODE_ADD, Q_MAX, Q_MAX, 0, '0);
    add_row(MODE_LOAD, Q_MIN, Q_MIN, 0, '0);
    add_row(MODE_SUB, Q_MAX, Q_MAX, 0, '0);
    add_row(MODE_MUL, Q_MIN, Q_MIN, 0, '0);
    add_row(MODE_LOAD, Q_MIN, 0, 0, '0);
    add_row(MODE_MUL, Q_MIN, 0, 0, '0);
    add_row(MODE_DIV, 1, 0, 0, '0);
    add_row(MODE_LOAD, 3 * Q_ONE, 4 * Q_ONE, 0, '0);
    add_row(MODE_MUL, 0, Q_ONE, 0, '0);
    add_row(MODE_DIV, 0, Q_ONE, 0, '0);
    add_row(MODE_DIV, Q_MIN, Q_MIN, 0, '0);
    add_row(MODE_LOAD, -5 * Q_ONE, 2 * Q_ONE, 0, '0);
    add_row(MODE_SPARE_5, Q_MAX, 0, 0, '0);
    add_row(MODE_SPARE_6, 0, Q_MIN, 0, '0);
    add_row(MODE_SPARE_7, -1, -1, 0, '0);
    add_row(MODE_LOAD, 0, 0, 0, '0);
    add_row(MODE_DIV, 0, 0, 0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send_request(rows[i].c, rows[i].typed, rows[i].r);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 400) hold_req = 1'b1;
      if (n == 900) begin
        cmd_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end
      if (n == RANDOM_ITEMS - 200) quiet = 1'b1;
      c.mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
      c.operand_re = rand_operand();
      c.operand_im = rand_operand();
      send_request(c, 0, '0);
    end
    cmd_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
